@@ design/curtain_mode_and_key_controller_defines.svh @@
// ---------------------------------------------------------------------------
// curtain controller assertion macros
// shared property wrappers for the curtain controller checks
// ---------------------------------------------------------------------------
`ifndef CURTAIN_MODE_AND_KEY_CONTROLLER_DEFINES_SVH
`define CURTAIN_MODE_AND_KEY_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CMKC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cmkc same-cycle check failed");

// next-cycle implication, disabled during reset
`define CMKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cmkc next-cycle check failed");

`endif

@@ design/cmkc_pkg.sv @@
// ---------------------------------------------------------------------------
// cmkc_pkg
// types and constants shared by the curtain controller modules
// ---------------------------------------------------------------------------
package cmkc_pkg;

	localparam logic [7:0] FULL_ANGLE      = 8'd180;
	localparam logic [7:0] COUNT_MAX       = 8'd255;
	localparam logic [6:0] DARK_RESET      = 7'd35;
	localparam logic [6:0] RAIN_RESET      = 7'd80;
	localparam logic [7:0] LONG_RESET      = 8'd25;

	typedef enum logic [1:0] {
		FUNC_KEY    = 2'd0,
		FUNC_AUTO   = 2'd1,
		FUNC_MODE   = 2'd2,
		FUNC_TARGET = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KEY_NONE    = 2'd0,
		KEY_MODE    = 2'd1,
		KEY_CURTAIN = 2'd2,
		KEY_SPARE   = 2'd3
	} key_t;

	typedef enum logic [1:0] {
		MOVE_NONE  = 2'd0,
		MOVE_CLOSE = 2'd1,
		MOVE_OPEN  = 2'd2
	} move_t;

	typedef enum logic [1:0] {
		PRESS_NONE  = 2'd0,
		PRESS_SHORT = 2'd1,
		PRESS_LONG  = 2'd2
	} press_t;

	typedef enum logic [1:0] {
		REPORT_NONE  = 2'd0,
		REPORT_APP   = 2'd1,
		REPORT_CLOUD = 2'd2
	} report_t;

	typedef enum logic [1:0] {
		CFG_DARK = 2'd0,
		CFG_RAIN = 2'd1,
		CFG_LONG = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0] dark_threshold;
		logic [6:0] rain_threshold;
		logic [7:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		func_t      func;
		key_t       key_code;
		logic [6:0] light_level;
		logic [6:0] rain_level;
		logic [7:0] remote_value;
		logic       net_connected;
	} item_t;

	typedef struct packed {
		logic       manual_mode;
		logic [7:0] target_angle;
		logic [7:0] actual_angle;
		logic [7:0] press_count;
		key_t       held_key;
		report_t    pending_report;
	} state_t;

	typedef struct packed {
		move_t      motor_move;
		logic [7:0] motor_angle;
		logic       mode_now;
		logic [7:0] curtain_position;
		press_t     press_kind;
		key_t       press_key;
		report_t    report_kind;
		logic       save_request;
	} result_t;

endpackage

@@ design/cmkc_step.sv @@
// ---------------------------------------------------------------------------
// cmkc_step
// next-state and result logic for one controller transaction
// ---------------------------------------------------------------------------
module cmkc_step (
	input  cmkc_pkg::item_t   item,
	input  cmkc_pkg::state_t  st,
	input  cmkc_pkg::cfg_t    cfg,
	output cmkc_pkg::state_t  st_nxt,
	output cmkc_pkg::result_t res
);

	logic [7:0] count_start;
	logic       is_dark;

	assign is_dark = (item.light_level < cfg.dark_threshold) ||
		(item.rain_level > cfg.rain_threshold);

	always_comb begin
		st_nxt      = st;
		res         = '0;
		count_start = st.press_count;
		case (item.func)
			cmkc_pkg::FUNC_KEY: begin
				if (item.key_code != cmkc_pkg::KEY_NONE) begin
					// first tick of a press latches the key and starts at one
					if (st.press_count == 8'd0) begin
						st_nxt.held_key = item.key_code;
						count_start     = 8'd1;
					end
					if ((count_start <= cfg.long_press_ticks) &&
						(count_start != cmkc_pkg::COUNT_MAX)) begin
						st_nxt.press_count = count_start + 8'd1;
					end else begin
						st_nxt.press_count = count_start;
					end
				end else if (st.press_count != 8'd0) begin
					res.press_key      = st.held_key;
					st_nxt.press_count = 8'd0;
					if (st.press_count < cfg.long_press_ticks) begin
						res.press_kind = cmkc_pkg::PRESS_SHORT;
						if (st.held_key == cmkc_pkg::KEY_MODE) begin
							st_nxt.manual_mode = ~st.manual_mode;
							res.save_request   = 1'b1;
						end else if ((st.held_key == cmkc_pkg::KEY_CURTAIN) &&
							st.manual_mode) begin
							if (st.target_angle == cmkc_pkg::FULL_ANGLE) begin
								res.motor_move      = cmkc_pkg::MOVE_CLOSE;
								st_nxt.target_angle = 8'd0;
								st_nxt.actual_angle = 8'd0;
							end else begin
								res.motor_move      = cmkc_pkg::MOVE_OPEN;
								st_nxt.target_angle = cmkc_pkg::FULL_ANGLE;
								st_nxt.actual_angle = cmkc_pkg::FULL_ANGLE;
							end
							res.motor_angle = cmkc_pkg::FULL_ANGLE;
						end
					end else begin
						res.press_kind = cmkc_pkg::PRESS_LONG;
						if (st.held_key == cmkc_pkg::KEY_MODE) begin
							st_nxt.pending_report = cmkc_pkg::REPORT_APP;
						end
					end
				end
			end
			cmkc_pkg::FUNC_AUTO: begin
				if (!st.manual_mode) begin
					if (is_dark) begin
						if (st.target_angle != 8'd0) begin
							st_nxt.target_angle = 8'd0;
							st_nxt.actual_angle = 8'd0;
							res.motor_move      = cmkc_pkg::MOVE_CLOSE;
							res.motor_angle     = cmkc_pkg::FULL_ANGLE;
						end
					end else if (st.target_angle != cmkc_pkg::FULL_ANGLE) begin
						st_nxt.target_angle = cmkc_pkg::FULL_ANGLE;
						st_nxt.actual_angle = cmkc_pkg::FULL_ANGLE;
						res.motor_move      = cmkc_pkg::MOVE_OPEN;
						res.motor_angle     = cmkc_pkg::FULL_ANGLE;
					end
				end else if (st.actual_angle != st.target_angle) begin
					if (st.target_angle > st.actual_angle) begin
						res.motor_move  = cmkc_pkg::MOVE_OPEN;
						res.motor_angle = st.target_angle - st.actual_angle;
					end else begin
						res.motor_move  = cmkc_pkg::MOVE_CLOSE;
						res.motor_angle = st.actual_angle - st.target_angle;
					end
					st_nxt.actual_angle = st.target_angle;
				end
				res.report_kind       = st.pending_report;
				st_nxt.pending_report = cmkc_pkg::REPORT_NONE;
			end
			cmkc_pkg::FUNC_MODE: begin
				st_nxt.manual_mode = (item.remote_value != 8'd0);
				if (item.net_connected && (st.pending_report == cmkc_pkg::REPORT_NONE)) begin
					st_nxt.pending_report = cmkc_pkg::REPORT_APP;
				end
				res.save_request = 1'b1;
			end
			cmkc_pkg::FUNC_TARGET: begin
				if (st.manual_mode) begin
					if (item.remote_value > cmkc_pkg::FULL_ANGLE) begin
						st_nxt.target_angle = cmkc_pkg::FULL_ANGLE;
					end else begin
						st_nxt.target_angle = item.remote_value;
					end
					if (item.net_connected &&
						(st.pending_report == cmkc_pkg::REPORT_NONE)) begin
						st_nxt.pending_report = cmkc_pkg::REPORT_APP;
					end
					res.save_request = 1'b1;
				end
			end
			default: begin
				st_nxt = st;
			end
		endcase
		res.mode_now         = st_nxt.manual_mode;
		res.curtain_position = st_nxt.target_angle;
	end

endmodule

@@ design/curtain_mode_and_key_controller.sv @@
// ---------------------------------------------------------------------------
// curtain_mode_and_key_controller
// key timing, auto/manual mode and curtain motor command generation
// ---------------------------------------------------------------------------
// An accepted item is held in the input register, then passes through the step
// logic into the result register when the step fires; a stall on the result
// channel can hold it in the input register.
// A new transaction is taken every cycle as long as the result register is
// empty or being drained in the same cycle, so sustained throughput is one
// transaction per clock; it is set by the single state update per cycle that
// the step logic performs between the input and result registers. Exactly one
// result comes out per transaction, in order. Thresholds and the long-press
// length come from the write port and must only change while idle.

`include "curtain_mode_and_key_controller_defines.svh"

module curtain_mode_and_key_controller (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [1:0] key_code,
	input  logic [6:0] light_level,
	input  logic [6:0] rain_level,
	input  logic [7:0] remote_value,
	input  logic       net_connected,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] motor_move,
	output logic [7:0] motor_angle,
	output logic       mode_now,
	output logic [7:0] curtain_position,
	output logic [1:0] press_kind,
	output logic [1:0] press_key,
	output logic [1:0] report_kind,
	output logic       save_request,
	// configuration writes
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cmkc_pkg::cfg_t    cfg_q;
	cmkc_pkg::state_t  st_q;
	cmkc_pkg::state_t  st_nxt;
	cmkc_pkg::item_t   item_s1;
	cmkc_pkg::result_t res_nxt;
	cmkc_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              fire;

	// step fires when an item is staged and the result slot is free or draining
	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;
	assign out_valid = out_valid_q;

	// configuration registers; unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold   <= cmkc_pkg::DARK_RESET;
			cfg_q.rain_threshold   <= cmkc_pkg::RAIN_RESET;
			cfg_q.long_press_ticks <= cmkc_pkg::LONG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cmkc_pkg::CFG_DARK: cfg_q.dark_threshold   <= cfg_wdata[6:0];
				cmkc_pkg::CFG_RAIN: cfg_q.rain_threshold   <= cfg_wdata[6:0];
				cmkc_pkg::CFG_LONG: cfg_q.long_press_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func          <= cmkc_pkg::func_t'(func);
			item_s1.key_code      <= cmkc_pkg::key_t'(key_code);
			item_s1.light_level   <= light_level;
			item_s1.rain_level    <= rain_level;
			item_s1.remote_value  <= remote_value;
			item_s1.net_connected <= net_connected;
		end
	end

	cmkc_step u_step (
		.item   (item_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// controller state advances once per fired transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.manual_mode    <= 1'b0;
			st_q.target_angle   <= 8'd0;
			st_q.actual_angle   <= 8'd0;
			st_q.press_count    <= 8'd0;
			st_q.held_key       <= cmkc_pkg::KEY_NONE;
			st_q.pending_report <= cmkc_pkg::REPORT_NONE;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign motor_move       = res_q.motor_move;
	assign motor_angle      = res_q.motor_angle;
	assign mode_now         = res_q.mode_now;
	assign curtain_position = res_q.curtain_position;
	assign press_kind       = res_q.press_kind;
	assign press_key        = res_q.press_key;
	assign report_kind      = res_q.report_kind;
	assign save_request     = res_q.save_request;

	// no motion means no angle
	`CMKC_ASSERT_NOW(a_idle_angle, clk, arst_n,
		out_valid_q && (res_q.motor_move == cmkc_pkg::MOVE_NONE), res_q.motor_angle == 8'd0)

	// target never leaves the travel range
	`CMKC_ASSERT_NOW(a_target_range, clk, arst_n, 1'b1, st_q.target_angle <= cmkc_pkg::FULL_ANGLE)

	// remote mode command sets the mode from the flag
	`CMKC_ASSERT_NEXT(a_remote_mode, clk, arst_n,
		fire && (item_s1.func == cmkc_pkg::FUNC_MODE),
		st_q.manual_mode == ($past(item_s1.remote_value) != 8'd0))

	// automation tick always clears the pending report
	`CMKC_ASSERT_NEXT(a_report_clear, clk, arst_n,
		fire && (item_s1.func == cmkc_pkg::FUNC_AUTO),
		st_q.pending_report == cmkc_pkg::REPORT_NONE)

endmodule
